// ----- hdl/tpt_pkg.sv -----
package tpt_pkg;

  localparam int UID_BYTES  = 7;
  localparam int UID_W      = 56;
  localparam int LEN_W      = 3;
  localparam int IDX_W      = 4;
  localparam int MAX_KNOWN  = 16;
  localparam int KT_AW      = $clog2(MAX_KNOWN);
  localparam int CNT_W      = 16;
  localparam int TRACK_W    = 16;
  localparam int RCNT_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 56;

  localparam logic [CNT_W-1:0]   CNT_MAX = '1;

  localparam logic [UID_W-1:0]   ERROR_UID_RST      = UID_W'(24'hADDBBA);
  localparam logic [LEN_W-1:0]   ERROR_UID_LEN_RST  = LEN_W'(4);
  localparam logic [CNT_W-1:0]   ABSENT_DEBOUNCE_RST = CNT_W'(400);
  localparam logic [CNT_W-1:0]   REPLAY_INTERVAL_RST = CNT_W'(2100);
  localparam logic [RCNT_W-1:0]  REPLAY_COUNT_RST    = RCNT_W'(3);
  localparam logic [TRACK_W-1:0] KNOWN_TRACK_RST     = TRACK_W'(1);
  localparam logic [TRACK_W-1:0] OTHER_TRACK_RST     = TRACK_W'(2);

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_READ   = 2'd1,
    CMD_NOREAD = 2'd2,
    CMD_LOAD   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    EVT_INSERT = 2'd0,
    EVT_REMOVE = 2'd1,
    EVT_REPLAY = 2'd2
  } event_t;

  typedef enum logic [1:0] {
    CLS_KNOWN   = 2'd0,
    CLS_UNKNOWN = 2'd1,
    CLS_ERROR   = 2'd2
  } tape_class_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ERROR_UID       = 3'd0,
    REG_ERROR_UID_LEN   = 3'd1,
    REG_ABSENT_DEBOUNCE = 3'd2,
    REG_REPLAY_INTERVAL = 3'd3,
    REG_REPLAY_COUNT    = 3'd4,
    REG_KNOWN_TRACK     = 3'd5,
    REG_OTHER_TRACK     = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic             en;
    logic [KT_AW-1:0] addr;
    logic [UID_W-1:0] uid;
    logic [LEN_W-1:0] len;
  } kt_wr_t;

  function automatic logic [UID_W-1:0] bytes_mask(input logic [LEN_W-1:0] len);
    logic [UID_W-1:0] m;
    m = '0;
    for (int b = 0; b < UID_BYTES; b++) begin
      if (b < int'(len)) begin
        m[b*8 +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

// ----- hdl/tpt_if.sv -----
interface tpt_cmd_if import tpt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       command;
  logic [UID_W-1:0] uid;
  logic [LEN_W-1:0] uid_len;
  logic [IDX_W-1:0] entry_index;

  modport source (output valid, command, uid, uid_len, entry_index, input ready);
  modport sink (input valid, command, uid, uid_len, entry_index, output ready);
endinterface

interface tpt_evt_if import tpt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         event_kind;
  logic [1:0]         tape_class;
  logic [TRACK_W-1:0] track;

  modport source (output valid, event_kind, tape_class, track, input ready);
  modport sink (input valid, event_kind, tape_class, track, output ready);
endinterface

// ----- hdl/tpt_known_table.sv -----
module tpt_known_table import tpt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  kt_wr_t           wr,
  input  logic [UID_W-1:0] uid,
  input  logic [LEN_W-1:0] len,
  output logic             hit
);

  logic [UID_W-1:0] ent_uid [MAX_KNOWN];
  logic [LEN_W-1:0] ent_len [MAX_KNOWN];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_KNOWN; i++) begin
        ent_len[i] <= '0;
      end
    end else if (wr.en) begin
      ent_len[wr.addr] <= wr.len;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      ent_uid[wr.addr] <= wr.uid;
    end
  end

  // Entries hold their UID already masked to their length.
  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < MAX_KNOWN; i++) begin
      if (ent_len[i] != '0 && ent_len[i] == len && ent_uid[i] == uid) begin
        hit = 1'b1;
      end
    end
  end

endmodule

// ----- hdl/tag_presence_tracker.sv -----
// Channel | Dir | Payload                                     | Transfer
// cmd_ch  | in  | command, uid, uid_len, entry_index          | valid && ready
// evt_ch  | out | event_kind, tape_class, track               | valid && ready
// cfg     | in  | cfg_wr_en, cfg_index, cfg_wdata             | cfg_wr_en
//
// One transaction is taken per cycle unless a stalled output backs up into a full
// input register; a result passes the input register, then the result register.
// The table lookup, UID compares and counter updates all sit between those two.
// A stalled output holds its result and stops the input register only when
// both are full. Reset is synchronous; the known-tag table reads empty at once.
module tag_presence_tracker import tpt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  tpt_cmd_if.sink               cmd_ch,
  tpt_evt_if.source             evt_ch,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [UID_W-1:0]   error_uid;
  logic [LEN_W-1:0]   error_uid_len;
  logic [CNT_W-1:0]   removal_hold_ms;
  logic [CNT_W-1:0]   replay_interval_ms;
  logic [RCNT_W-1:0]  replay_count;
  logic [TRACK_W-1:0] known_track;
  logic [TRACK_W-1:0] other_track;

  always_ff @(posedge clk) begin
    if (rst) begin
      error_uid          <= ERROR_UID_RST;
      error_uid_len      <= ERROR_UID_LEN_RST;
      removal_hold_ms    <= ABSENT_DEBOUNCE_RST;
      replay_interval_ms <= REPLAY_INTERVAL_RST;
      replay_count       <= REPLAY_COUNT_RST;
      known_track        <= KNOWN_TRACK_RST;
      other_track        <= OTHER_TRACK_RST;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_ERROR_UID:       error_uid          <= cfg_wdata[UID_W-1:0];
        REG_ERROR_UID_LEN:   error_uid_len      <= cfg_wdata[LEN_W-1:0];
        REG_ABSENT_DEBOUNCE: removal_hold_ms    <= cfg_wdata[CNT_W-1:0];
        REG_REPLAY_INTERVAL: replay_interval_ms <= cfg_wdata[CNT_W-1:0];
        REG_REPLAY_COUNT:    replay_count       <= cfg_wdata[RCNT_W-1:0];
        REG_KNOWN_TRACK:     known_track        <= cfg_wdata[TRACK_W-1:0];
        REG_OTHER_TRACK:     other_track        <= cfg_wdata[TRACK_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  logic             stage_valid;
  logic             stage_go;
  cmd_t             st_cmd;
  logic [UID_W-1:0] st_uid;
  logic [LEN_W-1:0] st_len;
  logic [IDX_W-1:0] st_idx;

  logic               out_valid;
  event_t             out_kind;
  tape_class_t        out_class;
  logic [TRACK_W-1:0] out_track;

  assign stage_go     = stage_valid && (!out_valid || evt_ch.ready);
  assign cmd_ch.ready = !stage_valid || stage_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (cmd_ch.ready) begin
      stage_valid <= cmd_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_ch.ready && cmd_ch.valid) begin
      st_cmd <= cmd_t'(cmd_ch.command);
      st_uid <= cmd_ch.uid;
      st_len <= cmd_ch.uid_len;
      st_idx <= cmd_ch.entry_index;
    end
  end

  // Tracking state.
  logic               tag_present, tag_present_next;
  logic [UID_W-1:0]   current_uid, current_uid_next;
  logic [LEN_W-1:0]   current_len, current_len_next;
  logic [CNT_W-1:0]   since_seen_ms, since_seen_ms_next;
  logic [RCNT_W-1:0]  replays_left, replays_left_next;
  logic [CNT_W-1:0]   since_play_ms, since_play_ms_next;

  logic [UID_W-1:0]   uid_m;
  logic               known_hit;
  logic               read_ok;
  logic               error_hit;
  logic [CNT_W-1:0]   seen_inc;
  logic [CNT_W-1:0]   play_inc;
  kt_wr_t             kt_wr;

  logic               res_valid;
  event_t             res_kind;
  tape_class_t        res_class;
  logic [TRACK_W-1:0] res_track;

  assign uid_m     = st_uid & bytes_mask(st_len);
  assign read_ok   = (st_cmd == CMD_READ) && (st_len != '0) && (int'(st_len) <= UID_BYTES);
  assign error_hit = (error_uid_len != '0) && (st_len == error_uid_len) &&
                     (uid_m == (error_uid & bytes_mask(error_uid_len)));
  assign seen_inc  = (since_seen_ms == CNT_MAX) ? since_seen_ms : since_seen_ms + CNT_W'(1);
  assign play_inc  = (since_play_ms == CNT_MAX) ? since_play_ms : since_play_ms + CNT_W'(1);

  assign kt_wr.en   = stage_go && (st_cmd == CMD_LOAD) && (int'(st_idx) < MAX_KNOWN);
  assign kt_wr.addr = st_idx[KT_AW-1:0];
  assign kt_wr.uid  = uid_m;
  assign kt_wr.len  = st_len;

  tpt_known_table u_known_table (
    .clk (clk),
    .rst (rst),
    .wr  (kt_wr),
    .uid (uid_m),
    .len (st_len),
    .hit (known_hit)
  );

  always_comb begin
    tag_present_next   = tag_present;
    current_uid_next   = current_uid;
    current_len_next   = current_len;
    since_seen_ms_next = since_seen_ms;
    replays_left_next  = replays_left;
    since_play_ms_next = since_play_ms;
    res_valid          = 1'b0;
    res_kind           = EVT_INSERT;
    res_class          = CLS_KNOWN;
    res_track          = '0;
    if (st_cmd == CMD_TICK) begin
      since_seen_ms_next = seen_inc;
      since_play_ms_next = play_inc;
      if (replays_left != '0 && play_inc >= replay_interval_ms) begin
        since_play_ms_next = '0;
        replays_left_next  = replays_left - RCNT_W'(1);
        res_valid          = 1'b1;
        res_kind           = EVT_REPLAY;
        res_track          = other_track;
      end
    end else if (st_cmd == CMD_LOAD) begin
      res_valid = 1'b0;
    end else if (read_ok) begin
      since_seen_ms_next = '0;
      if (!(tag_present && st_len == current_len && uid_m == current_uid)) begin
        tag_present_next   = 1'b1;
        current_uid_next   = uid_m;
        current_len_next   = st_len;
        since_play_ms_next = '0;
        res_valid          = 1'b1;
        res_kind           = EVT_INSERT;
        if (error_hit) begin
          res_class = CLS_ERROR;
        end else if (known_hit) begin
          res_class = CLS_KNOWN;
        end else begin
          res_class = CLS_UNKNOWN;
        end
        res_track = (res_class == CLS_KNOWN) ? known_track : other_track;
        replays_left_next = (res_class == CLS_KNOWN || replay_count == '0) ? '0
                            : replay_count - RCNT_W'(1);
      end
    end else if (tag_present && since_seen_ms >= removal_hold_ms) begin
      tag_present_next  = 1'b0;
      current_len_next  = '0;
      replays_left_next = '0;
      res_valid         = 1'b1;
      res_kind          = EVT_REMOVE;
      res_track         = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_present   <= 1'b0;
      current_uid   <= '0;
      current_len   <= '0;
      since_seen_ms <= '0;
      replays_left  <= '0;
      since_play_ms <= '0;
    end else if (stage_go) begin
      tag_present   <= tag_present_next;
      current_uid   <= current_uid_next;
      current_len   <= current_len_next;
      since_seen_ms <= since_seen_ms_next;
      replays_left  <= replays_left_next;
      since_play_ms <= since_play_ms_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_go) begin
      out_valid <= res_valid;
    end else if (evt_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_go && res_valid) begin
      out_kind  <= res_kind;
      out_class <= res_class;
      out_track <= res_track;
    end
  end

  assign evt_ch.valid      = out_valid;
  assign evt_ch.event_kind = out_kind;
  assign evt_ch.tape_class = out_class;
  assign evt_ch.track      = out_track;

  a_present_len: assert property (@(posedge clk) disable iff (rst)
    tag_present == (current_len != '0))
    else $error("tracked flag and stored length disagree");

  a_no_replay_idle: assert property (@(posedge clk) disable iff (rst)
    !tag_present |-> replays_left == '0)
    else $error("replays armed with no tag tracked");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !stage_go |=> stage_valid)
    else $error("stalled transaction dropped from the input register");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(stage_go))
    else $error("result appeared without a processed transaction");

endmodule
